[design/lfu_slot_cache_with_aging_core_assert.svh]
`ifndef LFU_SLOT_CACHE_WITH_AGING_CORE_ASSERT_SVH
`define LFU_SLOT_CACHE_WITH_AGING_CORE_ASSERT_SVH

// check cons in the same cycle as ante
`define LFUC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define LFUC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lfuc_pkg.sv]
`default_nettype none
package lfuc_pkg;

  localparam int SLOTS    = 16;
  localparam int KEYS     = 256;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int KEY_W    = $clog2(KEYS);
  localparam int USAGE_W  = 15;
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [USAGE_W-1:0] USAGE_MAX     = {USAGE_W{1'b1}};
  localparam logic [USAGE_W-1:0] AGE_LIMIT_RST = 15'd32000;
  localparam logic [USAGE_W-1:0] AGE_STEP_RST  = 15'd16000;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INVAL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

  localparam logic REG_AGE_LIMIT = 1'b0;
  localparam logic REG_AGE_STEP  = 1'b1;

  typedef struct packed {
    logic load;
    logic hit_update;
    logic flush;
    logic inval;
    logic scan_init;
    logic scan_step;
    logic rd_old;
    logic unmap_old;
    logic alloc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              hit_ok;
    logic              scan_end;
    logic              pick_valid;
    logic              out_free;
  } status_t;

endpackage
`default_nettype wire

[design/lfu_slot_cache_with_aging_core.sv]
// LFU slot cache with aging. Each 8-bit key may own one of 16 slots; a lookup
// returns the slot, with hit, created and evicted flags and the evicted key. A
// hit bumps the slot's usage count and, once it passes age_limit (byte address
// 0, reset 32000), every count drops by age_step (byte address 4, reset 16000).
// A miss scans the slots one per cycle for the first empty slot or the lowest
// count. A hit, invalidate or flush goes from dispatch to the result state; a
// miss adds the scan, the victim read and eviction check (if a live slot is
// evicted) and the allocation. The slot scan and the key-to-slot table's single
// read port, used once for the key and once for the evicted owner, set its length.
// The result state loads the output register once free. One transaction is in
// work at a time; a finished result may wait for out_stall while the next one is
// accepted, and that transaction then holds its result until the output frees.
`default_nettype none
module lfu_slot_cache_with_aging_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lfuc_pkg::KIND_W-1:0]   kind,
  input  wire logic [lfuc_pkg::KEY_W-1:0]    key,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [lfuc_pkg::SLOT_W-1:0]   slot,
  output logic                               hit,
  output logic                               created,
  output logic                               evicted,
  output logic      [lfuc_pkg::KEY_W-1:0]    evicted_key,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lfuc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [lfuc_pkg::DATA_W-1:0]   pwdata,
  output logic      [lfuc_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  lfuc_pkg::cmd_t              cmd;
  lfuc_pkg::status_t           status;
  logic [lfuc_pkg::USAGE_W-1:0] age_limit;
  logic [lfuc_pkg::USAGE_W-1:0] age_step;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= lfuc_pkg::AGE_LIMIT_RST;
      age_step  <= lfuc_pkg::AGE_STEP_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        lfuc_pkg::REG_AGE_LIMIT: age_limit <= pwdata[lfuc_pkg::USAGE_W-1:0];
        lfuc_pkg::REG_AGE_STEP:  age_step  <= pwdata[lfuc_pkg::USAGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lfuc_pkg::REG_AGE_LIMIT: prdata = lfuc_pkg::DATA_W'(age_limit);
      lfuc_pkg::REG_AGE_STEP:  prdata = lfuc_pkg::DATA_W'(age_step);
      default:                 prdata = '0;
    endcase
  end

  lfuc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  lfuc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_kind    (kind),
    .in_key     (key),
    .age_limit  (age_limit),
    .age_step   (age_step),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_slot   (slot),
    .out_hit    (hit),
    .out_created(created),
    .out_evicted(evicted),
    .out_ekey   (evicted_key)
  );

endmodule
`default_nettype wire

[design/lfuc_ram.sv]
`default_nettype none
module lfuc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/lfuc_ctrl.sv]
`default_nettype none
`include "lfu_slot_cache_with_aging_core_assert.svh"
module lfuc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire lfuc_pkg::status_t status,
  output lfuc_pkg::cmd_t        cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_VICTIM   = 3'd3;
  localparam logic [2:0] ST_EVCHK    = 3'd4;
  localparam logic [2:0] ST_ALLOC    = 3'd5;
  localparam logic [2:0] ST_RESULT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status.kind)
          lfuc_pkg::KIND_LOOKUP: begin
            if (status.hit_ok) begin
              cmd.hit_update = 1'b1;
              state_next     = ST_RESULT;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = ST_SCAN;
            end
          end
          lfuc_pkg::KIND_INVAL: begin
            cmd.inval  = 1'b1;
            state_next = ST_RESULT;
          end
          lfuc_pkg::KIND_FLUSH: begin
            cmd.flush  = 1'b1;
            state_next = ST_RESULT;
          end
          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_end) begin
          state_next = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        if (status.pick_valid) begin
          cmd.rd_old = 1'b1;
          state_next = ST_EVCHK;
        end else begin
          state_next = ST_ALLOC;
        end
      end
      ST_EVCHK: begin
        cmd.unmap_old = 1'b1;
        state_next    = ST_ALLOC;
      end
      ST_ALLOC: begin
        cmd.alloc  = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `LFUC_ASSERT_NEXT(a_load_dispatch, state == ST_IDLE && in_valid, state == ST_DISPATCH, "accepted transaction did not dispatch")
  `LFUC_ASSERT_NEXT(a_scan_exit, state == ST_SCAN && status.scan_end, state == ST_VICTIM, "scan did not end on scan_end")
  `LFUC_ASSERT_NEXT(a_alloc_result, state == ST_ALLOC, state == ST_RESULT, "allocation did not move to result")

endmodule
`default_nettype wire

[design/lfuc_dp.sv]
`default_nettype none
`include "lfu_slot_cache_with_aging_core_assert.svh"
module lfuc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lfuc_pkg::cmd_t                cmd,
  output lfuc_pkg::status_t                  status,
  input  wire logic [lfuc_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [lfuc_pkg::KEY_W-1:0]    in_key,
  input  wire logic [lfuc_pkg::USAGE_W-1:0]  age_limit,
  input  wire logic [lfuc_pkg::USAGE_W-1:0]  age_step,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [lfuc_pkg::SLOT_W-1:0]   out_slot,
  output logic                               out_hit,
  output logic                               out_created,
  output logic                               out_evicted,
  output logic      [lfuc_pkg::KEY_W-1:0]    out_ekey
);

  localparam int SW = lfuc_pkg::SLOT_W;
  localparam int KW = lfuc_pkg::KEY_W;
  localparam int UW = lfuc_pkg::USAGE_W;

  logic [lfuc_pkg::KIND_W-1:0] kind_q;
  logic [KW-1:0]               key_q;
  logic [KW-1:0]               old_q;

  logic [lfuc_pkg::KEYS-1:0]   mapped;
  logic [lfuc_pkg::SLOTS-1:0]  slot_valid;
  logic [UW-1:0]               usage [lfuc_pkg::SLOTS];
  logic [UW-1:0]               usage_next [lfuc_pkg::SLOTS];
  logic [KW-1:0]               owner [lfuc_pkg::SLOTS];

  logic [SW-1:0]               scan_idx;
  logic [SW-1:0]               pick;
  logic [UW-1:0]               umin;

  logic [SW-1:0]               res_slot;
  logic                        res_hit;
  logic                        res_created;
  logic                        res_evicted;
  logic [KW-1:0]               res_ekey;

  logic [KW-1:0]               ram_raddr;
  logic [SW-1:0]               ram_rdata;

  logic [UW:0]                 hit_n;
  logic                        do_age;
  logic [UW:0]                 base;
  logic [UW:0]                 aged;

  assign ram_raddr = cmd.rd_old ? owner[pick] : in_key;

  lfuc_ram #(
    .WIDTH(SW),
    .DEPTH(lfuc_pkg::KEYS)
  ) u_key_slot (
    .clk  (clk),
    .we   (cmd.alloc),
    .waddr(key_q),
    .wdata(pick),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign status.kind       = kind_q;
  assign status.hit_ok     = mapped[key_q] && slot_valid[ram_rdata] &&
                             (owner[ram_rdata] == key_q);
  assign status.scan_end   = !slot_valid[scan_idx] ||
                             (scan_idx == SW'(lfuc_pkg::SLOTS - 1));
  assign status.pick_valid = slot_valid[pick];
  assign status.out_free   = !out_valid || !out_stall;

  assign hit_n  = {1'b0, usage[ram_rdata]} + (UW+1)'(1);
  assign do_age = hit_n > {1'b0, age_limit};

  always_comb begin
    base = '0;
    aged = '0;
    for (int j = 0; j < lfuc_pkg::SLOTS; j++) begin
      base = (ram_rdata == SW'(j)) ? hit_n : {1'b0, usage[j]};
      aged = (base > {1'b0, age_step}) ? (base - {1'b0, age_step}) : '0;
      if (do_age) begin
        base = aged;
      end
      usage_next[j] = (base > {1'b0, lfuc_pkg::USAGE_MAX}) ? lfuc_pkg::USAGE_MAX
                                                            : base[UW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= in_kind;
      key_q  <= in_key;
    end
    if (cmd.rd_old) begin
      old_q <= owner[pick];
    end
    if (cmd.alloc) begin
      owner[pick] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.flush) begin
      slot_valid <= '0;
      for (int j = 0; j < lfuc_pkg::SLOTS; j++) begin
        usage[j] <= '0;
      end
    end else if (cmd.hit_update) begin
      for (int j = 0; j < lfuc_pkg::SLOTS; j++) begin
        usage[j] <= usage_next[j];
      end
    end else if (cmd.alloc) begin
      slot_valid[pick] <= 1'b1;
      usage[pick]      <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.flush) begin
      mapped <= '0;
    end else if (cmd.inval) begin
      mapped[key_q] <= 1'b0;
    end else if (cmd.unmap_old) begin
      if (mapped[old_q] && (ram_rdata == pick)) begin
        mapped[old_q] <= 1'b0;
      end
    end else if (cmd.alloc) begin
      mapped[key_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      if (!slot_valid[scan_idx]) begin
        pick <= scan_idx;
      end else if ((scan_idx == '0) || (usage[scan_idx] < umin)) begin
        pick <= scan_idx;
        umin <= usage[scan_idx];
      end
      scan_idx <= scan_idx + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_slot    <= '0;
      res_hit     <= 1'b0;
      res_created <= 1'b0;
      res_evicted <= 1'b0;
      res_ekey    <= '0;
    end else if (cmd.hit_update) begin
      res_slot <= ram_rdata;
      res_hit  <= 1'b1;
    end else if (cmd.rd_old) begin
      res_evicted <= 1'b1;
      res_ekey    <= owner[pick];
    end else if (cmd.alloc) begin
      res_slot    <= pick;
      res_created <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_slot    <= res_slot;
      out_hit     <= res_hit;
      out_created <= res_created;
      out_evicted <= res_evicted;
      out_ekey    <= res_ekey;
    end
  end

  `LFUC_ASSERT_NEXT(a_alloc_maps, cmd.alloc, mapped[key_q] && slot_valid[pick], "allocated key not mapped to a valid slot")
  `LFUC_ASSERT_NEXT(a_flush_clears, cmd.flush, slot_valid == '0 && mapped == '0, "flush left live entries")
  `LFUC_ASSERT_NOW(a_hit_xor_create, out_valid, !(out_hit && out_created), "result is both hit and created")

endmodule
`default_nettype wire
